// File: hw/rtl/gvms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvms_pkg
// Shared types and bit positions for the virtual CPU interface maintenance
// status unit.
// ----------------------------------------------------------------------------
package gvms_pkg;

  // Access codes carried by the command field
  typedef enum logic [1:0] {
    CMD_WRITE_LR   = 2'd0,
    CMD_WRITE_HCR  = 2'd1,
    CMD_WRITE_VMCR = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  localparam int unsigned MAX_LISTS  = 16;
  localparam int unsigned IDX_WIDTH  = 4;
  localparam int unsigned CNT_WIDTH  = 5;
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned MISR_WIDTH = 8;

  // List register bit positions
  localparam int unsigned LR_ACTIVE_BIT  = 63;
  localparam int unsigned LR_PENDING_BIT = 62;
  localparam int unsigned LR_HW_BIT      = 61;
  localparam int unsigned LR_EOI_BIT     = 41;

  // HCR bit positions
  localparam int unsigned HCR_UIE_BIT     = 1;
  localparam int unsigned HCR_LRENPIE_BIT = 2;
  localparam int unsigned HCR_NPIE_BIT    = 3;
  localparam int unsigned HCR_G0EIE_BIT   = 4;
  localparam int unsigned HCR_G0DIE_BIT   = 5;
  localparam int unsigned HCR_G1EIE_BIT   = 6;
  localparam int unsigned HCR_G1DIE_BIT   = 7;
  localparam int unsigned HCR_EOICNT_LSB  = 27;
  localparam int unsigned HCR_EOICNT_MSB  = 31;

  // VMCR bit positions
  localparam int unsigned VMCR_ENG0_BIT = 0;
  localparam int unsigned VMCR_ENG1_BIT = 1;

  // MISR bit positions
  localparam int unsigned MISR_EOI   = 0;
  localparam int unsigned MISR_U     = 1;
  localparam int unsigned MISR_LRENP = 2;
  localparam int unsigned MISR_NP    = 3;
  localparam int unsigned MISR_G0E   = 4;
  localparam int unsigned MISR_G0D   = 5;
  localparam int unsigned MISR_G1E   = 6;
  localparam int unsigned MISR_G1D   = 7;

  localparam logic [CNT_WIDTH-1:0] LISTS_IN_USE_RESET = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic state_write;   // apply the accepted access to the register file
    logic result_load;   // capture the status into the result register
  } dp_cmd_t;

endpackage

// File: hw/rtl/gvms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvms_ctrl
// Sequencer for one access: update on accept, then evaluate and hand the
// status to the result register.
// ----------------------------------------------------------------------------
module gvms_ctrl
  import gvms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output dp_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  state_t state;

  assign req_stall       = (state == ST_EVAL);
  assign cmd.state_write = (state == ST_IDLE) && req_valid;
  assign cmd.result_load = (state == ST_EVAL) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (cmd.result_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // hold the result until the far side takes it
      if (cmd.result_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_one_access_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second access accepted while one is in flight");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while stalled");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> rsp_valid)
    else $error("loaded result not presented");

  a_taken_result_drops: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && !cmd.result_load) |=> !rsp_valid)
    else $error("result repeated after transfer");

endmodule

// File: hw/rtl/gvms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvms_datapath
// List register flags, HCR and VMCR fields, status evaluation and the
// result register.
// ----------------------------------------------------------------------------
module gvms_datapath
  import gvms_pkg::*;
#(
  parameter int unsigned NUM_LISTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  input  logic [1:0]             command,
  input  logic [IDX_WIDTH-1:0]   list_index,
  input  logic [DATA_WIDTH-1:0]  write_data,
  input  logic                   cfg_write_enable,
  input  logic [CNT_WIDTH-1:0]   cfg_write_data,
  output logic [MAX_LISTS-1:0]   eoi_status,
  output logic [MAX_LISTS-1:0]   empty_status,
  output logic [MISR_WIDTH-1:0]  maintenance_status
);

  // Only the state, HW and EOI bits of a list register reach the status,
  // so keep those: {active, pending, hw, eoi}
  typedef struct packed {
    logic active;
    logic pending;
    logic hw;
    logic eoi;
  } lr_flags_t;

  lr_flags_t               lr_flags [NUM_LISTS];
  logic [CNT_WIDTH-1:0]    lists_in_use;
  logic [6:0]              hcr_enables;   // HCR bits 7..1
  logic [4:0]              hcr_eoi_count;
  logic [1:0]              vmcr_eng;

  logic [MAX_LISTS-1:0]    eoi_vec;
  logic [MAX_LISTS-1:0]    empty_vec;
  logic [MAX_LISTS-1:0]    used_vec;
  logic [MAX_LISTS-1:0]    pend_vec;
  logic                    at_most_one;
  logic [MISR_WIDTH-1:0]   misr;
  cmd_t                    op;

  assign op = cmd_t'(command);

  always_ff @(posedge clk) begin
    if (rst) begin
      lists_in_use <= LISTS_IN_USE_RESET;
    end else if (cfg_write_enable) begin
      lists_in_use <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcr_enables   <= '0;
      hcr_eoi_count <= '0;
      vmcr_eng      <= '0;
    end else if (cmd.state_write) begin
      if (op == CMD_WRITE_HCR) begin
        hcr_enables   <= write_data[HCR_G1DIE_BIT:HCR_UIE_BIT];
        hcr_eoi_count <= write_data[HCR_EOICNT_MSB:HCR_EOICNT_LSB];
      end
      if (op == CMD_WRITE_VMCR) begin
        vmcr_eng <= write_data[VMCR_ENG1_BIT:VMCR_ENG0_BIT];
      end
    end
  end

  for (genvar i = 0; i < MAX_LISTS; i++) begin : g_lr
    if (i < NUM_LISTS) begin : g_impl
      logic scanned;

      always_ff @(posedge clk) begin
        if (rst) begin
          lr_flags[i] <= '0;
        end else if (cmd.state_write && (op == CMD_WRITE_LR) &&
                     (list_index == IDX_WIDTH'(i))) begin
          lr_flags[i] <= '{active:  write_data[LR_ACTIVE_BIT],
                           pending: write_data[LR_PENDING_BIT],
                           hw:      write_data[LR_HW_BIT],
                           eoi:     write_data[LR_EOI_BIT]};
        end
      end

      assign scanned      = (CNT_WIDTH'(i) < lists_in_use);
      assign empty_vec[i] = scanned && !lr_flags[i].active && !lr_flags[i].pending;
      assign eoi_vec[i]   = empty_vec[i] && !lr_flags[i].hw && lr_flags[i].eoi;
      assign used_vec[i]  = scanned && (lr_flags[i].active || lr_flags[i].pending);
      assign pend_vec[i]  = scanned && lr_flags[i].pending;
    end else begin : g_absent
      assign empty_vec[i] = 1'b0;
      assign eoi_vec[i]   = 1'b0;
      assign used_vec[i]  = 1'b0;
      assign pend_vec[i]  = 1'b0;
    end
  end

  // clearing the lowest set bit leaves nothing when at most one is set
  assign at_most_one = ((used_vec & (used_vec - MAX_LISTS'(1))) == '0);

  always_comb begin
    misr             = '0;
    misr[MISR_EOI]   = |eoi_vec;
    misr[MISR_U]     = hcr_enables[HCR_UIE_BIT-1] && at_most_one;
    misr[MISR_LRENP] = hcr_enables[HCR_LRENPIE_BIT-1] && (hcr_eoi_count != '0);
    misr[MISR_NP]    = hcr_enables[HCR_NPIE_BIT-1] && !(|pend_vec);
    misr[MISR_G0E]   = hcr_enables[HCR_G0EIE_BIT-1] && vmcr_eng[VMCR_ENG0_BIT];
    misr[MISR_G0D]   = hcr_enables[HCR_G0DIE_BIT-1] && !vmcr_eng[VMCR_ENG0_BIT];
    misr[MISR_G1E]   = hcr_enables[HCR_G1EIE_BIT-1] && vmcr_eng[VMCR_ENG1_BIT];
    misr[MISR_G1D]   = hcr_enables[HCR_G1DIE_BIT-1] && !vmcr_eng[VMCR_ENG1_BIT];
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      eoi_status         <= eoi_vec;
      empty_status       <= empty_vec;
      maintenance_status <= misr;
    end
  end

endmodule

// File: hw/rtl/gic_virtual_maintenance_status_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_virtual_maintenance_status_unit
// GICv3 virtual CPU interface list registers, HCR and VMCR with EISR, ELRSR
// and MISR status returned on every access.
// ----------------------------------------------------------------------------
// Each request transfer either writes one list register, writes HCR, writes
// VMCR, or only reads; it always yields exactly one response transfer with
// EISR (eoi_status), ELRSR (empty_status) and MISR (maintenance_status) as
// they stand after the write. The register file is updated at the accepting
// edge; the status of the first lists_in_use list registers (capped at
// NUM_LISTS) is then evaluated and loaded into the result register once
// that register is free. The result register is the only buffer: a new
// request is taken while an old result waits, but its evaluation waits for
// that result to be transferred, so rsp_stall holds it in evaluation. List
// register writes with list_index at or above NUM_LISTS are dropped; HCR
// keeps bits 7..1 and 31..27 of write_data and VMCR keeps bits 1..0.
// Write lists_in_use only while no access is outstanding. No clearing pass
// follows reset: all but the result register are reset in the reset cycle.
// ----------------------------------------------------------------------------
module gic_virtual_maintenance_status_unit
  import gvms_pkg::*;
#(
  parameter int unsigned NUM_LISTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            command,
  input  logic [IDX_WIDTH-1:0]  list_index,
  input  logic [DATA_WIDTH-1:0] write_data,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [MAX_LISTS-1:0]  eoi_status,
  output logic [MAX_LISTS-1:0]  empty_status,
  output logic [MISR_WIDTH-1:0] maintenance_status,
  // lists_in_use register
  input  logic                  cfg_write_enable,
  input  logic [CNT_WIDTH-1:0]  cfg_write_data
);

  dp_cmd_t dp_cmd;

  // Sequence the access: accept, evaluate, hand over
  gvms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (dp_cmd)
  );

  // Hold the register file and build the status bitmaps
  gvms_datapath #(
    .NUM_LISTS (NUM_LISTS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (dp_cmd),
    .command            (command),
    .list_index         (list_index),
    .write_data         (write_data),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_write_data     (cfg_write_data),
    .eoi_status         (eoi_status),
    .empty_status       (empty_status),
    .maintenance_status (maintenance_status)
  );

endmodule
